// ----- sv/lhc_pkg.sv -----
// Shared types, widths, codes and angle constants of the lookahead heading controller.
package lhc_pkg;

	localparam int COORD_W      = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int Q_W          = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int MAG_W        = (DIFF_W > 33) ? DIFF_W : 33;
	localparam int DIST_W       = 32;
	localparam int MUL_W        = 33;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int SQ_W         = 2 * DIST_W;
	localparam int CW           = 58;
	localparam int ANG_W        = 34;
	localparam int ERR_W        = 36;
	localparam int ACC_W        = 36;
	localparam int STEP_W       = 5;
	localparam int IN_FIELDS_W  = 2 * COORD_W + 4 * Q_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W   = 32;
	localparam int CFG_W        = 32;

	localparam logic [DIST_W-1:0]     DIST_MAX    = '1;
	localparam logic signed [CW-1:0]  NORM_LIM    = CW'(64'h0010_0000_0000_0000);
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1686629713);
	localparam logic signed [ERR_W-1:0] ANG_PI      = ERR_W'(64'sd3373259426);
	localparam logic signed [ERR_W-1:0] ANG_TWO_PI  = ERR_W'(64'sd6746518852);

	typedef enum logic [1:0] {OP_FIRST, OP_NEXT, OP_ODOM, OP_EMPTY} op_t;
	typedef enum logic [1:0] {PS_NONE, PS_PATH, PS_EMPTY} path_t;
	typedef enum logic [1:0] {RES_DRIVING, RES_GOAL, RES_EMPTY} res_t;
	typedef enum logic [1:0] {REG_LOOKAHEAD, REG_GOAL_TOL, REG_SPEED, REG_GAIN} reg_t;

	typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT} cordic_st_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_DIFF, S_SQX, S_SQY, S_SQRT, S_DIST, S_QMUL,
		S_YAWCHK, S_YAW, S_TGT, S_WRAP, S_MAG, S_GAIN, S_OUT
	} ctrl_st_t;

	// arctangent of 2^-i, Q30 radians
	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		begin
			case (i)
				5'd0:  v = 32'd843314857;
				5'd1:  v = 32'd497837829;
				5'd2:  v = 32'd263043836;
				5'd3:  v = 32'd133525158;
				5'd4:  v = 32'd67021686;
				5'd5:  v = 32'd33543515;
				5'd6:  v = 32'd16775850;
				5'd7:  v = 32'd8388437;
				5'd8:  v = 32'd4194282;
				5'd9:  v = 32'd2097149;
				5'd10: v = 32'd1048576;
				5'd11: v = 32'd524288;
				5'd12: v = 32'd262144;
				5'd13: v = 32'd131072;
				5'd14: v = 32'd65536;
				5'd15: v = 32'd32768;
				5'd16: v = 32'd16384;
				5'd17: v = 32'd8192;
				5'd18: v = 32'd4096;
				5'd19: v = 32'd2048;
				5'd20: v = 32'd1024;
				5'd21: v = 32'd512;
				5'd22: v = 32'd256;
				5'd23: v = 32'd128;
				default: v = 32'd0;
			endcase
			return signed'(ANG_W'(v));
		end
	endfunction

endpackage

// ----- sv/lookahead_heading_controller.sv -----
// Lookahead heading controller top level: request sequencer, path state and result register.
//
// Path points (op 0 start, op 1 append) and odometry requests (op 2) enter on the s_axis
// side one at a time; op 3 marks an empty path. An odometry request against a known path
// returns one command on m_axis, a finished command waits in an output register while the
// next request is taken. A start-of-path or empty-path request needs only the decode step,
// an appended point at most two bit-serial squarings and a bit-serial square root, and an
// odometry request at most the same distance work, eight quaternion products and
// the heading gain on the shared one-bit-per-cycle multiplier, plus up to two CORDIC runs of up
// to 52 prescale shifts and 16 rotations each. Configuration writes are taken at any time.
module lookahead_heading_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
	input  logic [lhc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// op
	input  logic [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// linear_cmd, angular_cmd
	output logic [lhc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// status
	output logic [1:0]                          m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [lhc_pkg::CFG_W-1:0]           cfg_data
);
	import lhc_pkg::*;

	ctrl_st_t state_q, state_d;

	// configuration
	logic [31:0] lookahead_q, goal_tol_q;
	logic [15:0] speed_q;
	logic [14:0] gain_q;

	// path state
	path_t                      path_q;
	logic                       found_q;
	logic [DIST_W-1:0]          travelled_q;
	logic signed [COORD_W-1:0]  prev_x_q, prev_y_q, target_x_q, target_y_q;

	// request
	op_t                        op_q;
	logic signed [COORD_W-1:0]  px_q, py_q;
	logic signed [Q_W-1:0]      qx_q, qy_q, qz_q, qw_q;

	// working registers
	logic signed [DIFF_W-1:0]   dx_q, dy_q;
	logic [SQ_W-1:0]            sq_q;
	logic [DIST_W-1:0]          dist_q;
	logic [2:0]                 k_q;
	logic                       qsign_q;
	logic signed [ACC_W-1:0]    d_q, m_q, ny_q, nx_q;
	logic signed [ANG_W-1:0]    yaw_q;
	logic signed [ERR_W-1:0]    err_q;
	logic                       err_neg_q;
	res_t                       res_status_q;
	logic [15:0]                res_lin_q, res_ang_q;

	// output register
	logic                       out_valid_q;
	res_t                       out_status_q;
	logic [15:0]                out_lin_q, out_ang_q;

	// units
	logic                       mul_start, mul_done;
	logic [MUL_W-1:0]           mul_a, mul_b;
	logic [PROD_W-1:0]          mul_prod;
	logic                       sqrt_start, sqrt_done;
	logic [DIST_W-1:0]          sqrt_root;
	logic                       cor_start, cor_done;
	logic signed [CW-1:0]       cor_x, cor_y;
	logic signed [ANG_W-1:0]    cor_z;

	// combinational helpers
	logic [DIFF_W-1:0]          ax, ay;
	logic                       dist_ovf;
	logic [SQ_W:0]              sq_sum;
	logic [DIST_W:0]            trav_sum;
	logic [2:0]                 k_sel;
	logic signed [Q_W-1:0]      qa, qb;
	logic [Q_W:0]               qa_m, qb_m;
	logic signed [ACC_W-1:0]    pval;
	logic [ACC_W-1:0]           m_mag;
	logic                       yaw_zero;
	logic signed [ERR_W-1:0]    e1, e2;
	logic [ERR_W-1:0]           err_mag;
	logic [50:0]                rsum;
	logic [20:0]                r_raw;
	logic [15:0]                r_sat;
	logic                       accept, out_load;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {out_ang_q, out_lin_q};

	assign ax       = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
	assign ay       = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
	assign dist_ovf = (MAG_W'(ax) > MAG_W'(DIST_MAX)) || (MAG_W'(ay) > MAG_W'(DIST_MAX));
	assign sq_sum   = {1'b0, sq_q} + {1'b0, mul_prod[SQ_W-1:0]};
	assign trav_sum = {1'b0, travelled_q} + {1'b0, dist_q};

	// quaternion product pairs: xx yy zz ww xz wy xy wz
	assign k_sel = (state_q == S_DIST) ? 3'd0 : k_q + 3'd1;
	always_comb begin
		case (k_sel)
			3'd0: begin qa = qx_q; qb = qx_q; end
			3'd1: begin qa = qy_q; qb = qy_q; end
			3'd2: begin qa = qz_q; qb = qz_q; end
			3'd3: begin qa = qw_q; qb = qw_q; end
			3'd4: begin qa = qx_q; qb = qz_q; end
			3'd5: begin qa = qw_q; qb = qy_q; end
			3'd6: begin qa = qx_q; qb = qy_q; end
			default: begin qa = qw_q; qb = qz_q; end
		endcase
	end
	assign qa_m = qa[Q_W-1] ? (Q_W + 1)'(-{qa[Q_W-1], qa}) : {1'b0, qa};
	assign qb_m = qb[Q_W-1] ? (Q_W + 1)'(-{qb[Q_W-1], qb}) : {1'b0, qb};
	assign pval = qsign_q ? -signed'(ACC_W'(mul_prod[2*Q_W+1:0]))
	                      : signed'(ACC_W'(mul_prod[2*Q_W+1:0]));

	assign m_mag    = m_q[ACC_W-1] ? ACC_W'(-m_q) : ACC_W'(m_q);
	assign yaw_zero = (d_q == '0) || ({m_mag, 1'b0} >= {1'b0, d_q});

	assign e1      = (err_q > ANG_PI) ? err_q - ANG_TWO_PI : err_q;
	assign e2      = (e1 < -ANG_PI) ? e1 + ANG_TWO_PI : e1;
	assign err_mag = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);

	// round half away from zero on the magnitude, then saturate
	assign rsum  = {1'b0, mul_prod[49:0]} + 51'(64'd1 << 29);
	assign r_raw = rsum[50:30];
	assign r_sat = (r_raw > 21'd32767) ? 16'd32767 : {1'b0, r_raw[14:0]};

	lhc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	lhc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sq_sum[SQ_W-1:0]),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	lhc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x_in   (cor_x),
		.y_in   (cor_y),
		.done   (cor_done),
		.z_out  (cor_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		sqrt_start = 1'b0;
		cor_start  = 1'b0;
		cor_x      = '0;
		cor_y      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (op_q)
					OP_NEXT: state_d = (path_q == PS_PATH) ? S_DIFF : S_IDLE;
					OP_ODOM: begin
						if (path_q == PS_NONE) state_d = S_IDLE;
						else if (path_q == PS_EMPTY) state_d = S_OUT;
						else state_d = S_DIFF;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DIFF: begin
				if (dist_ovf) begin
					state_d = S_DIST;
				end else begin
					mul_start = 1'b1;
					mul_a     = MUL_W'(ax);
					mul_b     = MUL_W'(ax);
					state_d   = S_SQX;
				end
			end
			S_SQX: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = MUL_W'(ay);
					mul_b     = MUL_W'(ay);
					state_d   = S_SQY;
				end
			end
			S_SQY: begin
				if (mul_done) begin
					if (sq_sum[SQ_W]) begin
						state_d = S_DIST;
					end else begin
						sqrt_start = 1'b1;
						state_d    = S_SQRT;
					end
				end
			end
			S_SQRT: begin
				if (sqrt_done) state_d = S_DIST;
			end
			S_DIST: begin
				if (op_q == OP_NEXT) begin
					state_d = S_IDLE;
				end else if (dist_q < goal_tol_q) begin
					state_d = S_OUT;
				end else begin
					mul_start = 1'b1;
					mul_a     = MUL_W'(qa_m);
					mul_b     = MUL_W'(qb_m);
					state_d   = S_QMUL;
				end
			end
			S_QMUL: begin
				if (mul_done) begin
					if (k_q == 3'd7) begin
						state_d = S_YAWCHK;
					end else begin
						mul_start = 1'b1;
						mul_a     = MUL_W'(qa_m);
						mul_b     = MUL_W'(qb_m);
					end
				end
			end
			S_YAWCHK: begin
				cor_start = 1'b1;
				if (yaw_zero) begin
					cor_x   = CW'(dx_q);
					cor_y   = CW'(dy_q);
					state_d = S_TGT;
				end else begin
					cor_x   = CW'(nx_q);
					cor_y   = CW'(ny_q) <<< 1;
					state_d = S_YAW;
				end
			end
			S_YAW: begin
				if (cor_done) begin
					cor_start = 1'b1;
					cor_x     = CW'(dx_q);
					cor_y     = CW'(dy_q);
					state_d   = S_TGT;
				end
			end
			S_TGT: begin
				if (cor_done) state_d = S_WRAP;
			end
			S_WRAP: begin
				state_d = S_MAG;
			end
			S_MAG: begin
				mul_start = 1'b1;
				mul_a     = MUL_W'(err_mag);
				mul_b     = MUL_W'(gain_q);
				state_d   = S_GAIN;
			end
			S_GAIN: begin
				if (mul_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration, path state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookahead_q <= 32'd65536;
			goal_tol_q  <= 32'd6554;
			speed_q     <= 16'd128;
			gain_q      <= 15'd5734;
			path_q      <= PS_NONE;
			found_q     <= 1'b0;
			travelled_q <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			target_x_q  <= '0;
			target_y_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (reg_t'(cfg_index))
					REG_LOOKAHEAD: lookahead_q <= cfg_data[31:0];
					REG_GOAL_TOL:  goal_tol_q  <= cfg_data[31:0];
					REG_SPEED:     speed_q     <= cfg_data[15:0];
					REG_GAIN:      gain_q      <= cfg_data[14:0];
					default:       lookahead_q <= lookahead_q;
				endcase
			end

			if (state_q == S_DECODE) begin
				case (op_q)
					OP_FIRST: begin
						prev_x_q    <= px_q;
						prev_y_q    <= py_q;
						target_x_q  <= px_q;
						target_y_q  <= py_q;
						travelled_q <= '0;
						found_q     <= 1'b0;
						path_q      <= PS_PATH;
					end
					OP_EMPTY: begin
						path_q      <= PS_EMPTY;
						found_q     <= 1'b0;
						travelled_q <= '0;
					end
					default: begin
						path_q <= path_q;
					end
				endcase
			end

			if ((state_q == S_DIST) && (op_q == OP_NEXT)) begin
				travelled_q <= trav_sum[DIST_W] ? DIST_MAX : trav_sum[DIST_W-1:0];
				// freeze the target once the lookahead distance is reached
				if (!found_q) begin
					target_x_q <= px_q;
					target_y_q <= py_q;
					if (trav_sum >= {1'b0, lookahead_q}) found_q <= 1'b1;
				end
				prev_x_q <= px_q;
				prev_y_q <= py_q;
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(s_axis_tuser);
			px_q <= s_axis_tdata[COORD_W-1:0];
			py_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
			qx_q <= s_axis_tdata[2*COORD_W+Q_W-1:2*COORD_W];
			qy_q <= s_axis_tdata[2*COORD_W+2*Q_W-1:2*COORD_W+Q_W];
			qz_q <= s_axis_tdata[2*COORD_W+3*Q_W-1:2*COORD_W+2*Q_W];
			qw_q <= s_axis_tdata[2*COORD_W+4*Q_W-1:2*COORD_W+3*Q_W];
		end

		if (state_q == S_DECODE) begin
			if (op_q == OP_NEXT) begin
				dx_q <= DIFF_W'(px_q) - DIFF_W'(prev_x_q);
				dy_q <= DIFF_W'(py_q) - DIFF_W'(prev_y_q);
			end else begin
				dx_q <= DIFF_W'(target_x_q) - DIFF_W'(px_q);
				dy_q <= DIFF_W'(target_y_q) - DIFF_W'(py_q);
			end
			res_status_q <= RES_EMPTY;
			res_lin_q    <= '0;
			res_ang_q    <= '0;
		end

		if ((state_q == S_DIFF) && dist_ovf) dist_q <= DIST_MAX;
		if ((state_q == S_SQX) && mul_done) sq_q <= mul_prod[SQ_W-1:0];
		if ((state_q == S_SQY) && mul_done && sq_sum[SQ_W]) dist_q <= DIST_MAX;
		if ((state_q == S_SQRT) && sqrt_done) dist_q <= sqrt_root;

		if (state_q == S_DIST) begin
			k_q          <= '0;
			d_q          <= '0;
			m_q          <= '0;
			ny_q         <= '0;
			nx_q         <= '0;
			res_status_q <= RES_GOAL;
		end

		if (mul_start && ((state_q == S_DIST) || (state_q == S_QMUL))) begin
			qsign_q <= qa[Q_W-1] ^ qb[Q_W-1];
		end

		if ((state_q == S_QMUL) && mul_done) begin
			k_q <= k_q + 3'd1;
			case (k_q) inside
				3'd0, 3'd3: begin
					d_q  <= d_q + pval;
					nx_q <= nx_q + pval;
				end
				3'd1, 3'd2: begin
					d_q  <= d_q + pval;
					nx_q <= nx_q - pval;
				end
				3'd4: m_q <= m_q + pval;
				3'd5: m_q <= m_q - pval;
				default: ny_q <= ny_q + pval;
			endcase
		end

		if ((state_q == S_YAWCHK) && yaw_zero) yaw_q <= '0;
		if ((state_q == S_YAW) && cor_done) yaw_q <= cor_z;
		if ((state_q == S_TGT) && cor_done) err_q <= ERR_W'(cor_z) - ERR_W'(yaw_q);
		if (state_q == S_WRAP) err_q <= e2;
		if (state_q == S_MAG) err_neg_q <= err_q[ERR_W-1];

		if ((state_q == S_GAIN) && mul_done) begin
			res_status_q <= RES_DRIVING;
			res_lin_q    <= speed_q;
			res_ang_q    <= err_neg_q ? 16'(-r_sat) : r_sat;
		end

		if (out_load) begin
			out_status_q <= res_status_q;
			out_lin_q    <= res_lin_q;
			out_ang_q    <= res_ang_q;
		end
	end

endmodule

// ----- sv/lhc_mul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module lhc_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lhc_pkg::MUL_W-1:0]  a,
	input  logic [lhc_pkg::MUL_W-1:0]  b,
	output logic                       done,
	output logic [lhc_pkg::PROD_W-1:0] prod
);
	import lhc_pkg::*;

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic [MUL_W-1:0]  a_q;
	logic [PROD_W-1:0] p_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_W:0]    hi;

	assign hi   = {1'b0, p_q[PROD_W-1:MUL_W]} + (p_q[0] ? {1'b0, a_q} : '0);
	assign done = done_q;
	assign prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the product right, add the multiplicand into the top half
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {hi, p_q[MUL_W-1:1]};
		end
	end

endmodule

// ----- sv/lhc_sqrt.sv -----
// Restoring integer square root, one result bit (two radicand bits) per cycle.
module lhc_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lhc_pkg::SQ_W-1:0]   rad,
	output logic                       done,
	output logic [lhc_pkg::DIST_W-1:0] root
);
	import lhc_pkg::*;

	localparam int CNT_W = $clog2(DIST_W);
	localparam int REM_W = DIST_W + 2;

	logic [SQ_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIST_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  rem2;
	logic [REM_W+1:0]  trial;

	assign rem2  = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
	assign trial = (REM_W + 2)'({root_q, 2'b01});
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIST_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (rem2 >= trial) begin
				rem_q  <= REM_W'(rem2 - trial);
				root_q <= {root_q[DIST_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem2);
				root_q <= {root_q[DIST_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ----- sv/lhc_cordic.sv -----
// CORDIC vectoring unit: quadrant fold, one-bit-per-cycle prescale, then rotations.
module lhc_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [lhc_pkg::CW-1:0]    x_in,
	input  logic signed [lhc_pkg::CW-1:0]    y_in,
	output logic                             done,
	output logic signed [lhc_pkg::ANG_W-1:0] z_out
);
	import lhc_pkg::*;

	cordic_st_t              state_q, state_d;
	logic signed [CW-1:0]    x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [STEP_W-1:0]       i_q;
	logic                    done_q;
	logic                    in_zero;
	logic                    below_lim;
	logic                    last;

	assign in_zero   = (x_in == '0) && (y_in == '0);
	assign below_lim = (x_q < NORM_LIM) && (x_q > -NORM_LIM) &&
	                   (y_q < NORM_LIM) && (y_q > -NORM_LIM);
	assign last      = (i_q == STEP_W'(CORDIC_STEPS - 1));
	assign done      = done_q;
	assign z_out     = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == C_IDLE) && start && in_zero) ||
			           ((state_q == C_ROT) && last);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: if (start && !in_zero) state_d = C_NORM;
			C_NORM: if (!below_lim) state_d = C_ROT;
			C_ROT:  if (last) state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					if (in_zero) begin
						z_q <= '0;
					end else if (x_in[CW-1]) begin
						// fold the left half plane by a quarter turn
						if (!y_in[CW-1]) begin
							x_q <= y_in;
							y_q <= -x_in;
							z_q <= ANG_HALF_PI;
						end else begin
							x_q <= -y_in;
							y_q <= x_in;
							z_q <= -ANG_HALF_PI;
						end
					end else begin
						x_q <= x_in;
						y_q <= y_in;
						z_q <= '0;
					end
				end
			end
			C_NORM: begin
				if (below_lim) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end else begin
					i_q <= '0;
				end
			end
			C_ROT: begin
				if (!y_q[CW-1]) begin
					x_q <= x_q + (y_q >>> i_q);
					y_q <= y_q - (x_q >>> i_q);
					z_q <= z_q + atan_entry(i_q);
				end else begin
					x_q <= x_q - (y_q >>> i_q);
					y_q <= y_q + (x_q >>> i_q);
					z_q <= z_q - atan_entry(i_q);
				end
				i_q <= i_q + 1'b1;
			end
			default: begin
				i_q <= '0;
			end
		endcase
	end

endmodule
